FILE: rtl/assert_macros.svh
// Assertion helpers for the allocator top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition implies a consequence on the same edge
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Check that a condition implies a consequence on the next edge
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: rtl/sba_pkg.sv
// ----------------------------------------------------------------------------
// Slab bitmap allocator package
// Shared payload types, status codes and size class constants.
// ----------------------------------------------------------------------------
package sba_pkg;

  localparam int NUM_CLASSES = 9;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_BAD_SIZE = 3'd1;
  localparam logic [2:0] ST_LARGE    = 3'd2;
  localparam logic [2:0] ST_NO_SLABS = 3'd3;
  localparam logic [2:0] ST_DOUBLE   = 3'd4;
  localparam logic [2:0] ST_FOREIGN  = 3'd5;

  localparam logic [23:0] BIG_LIMIT = 24'd8388608;

  typedef struct packed {
    logic        req_type;
    logic [23:0] request_size;
    logic [3:0]  free_class;
    logic [1:0]  free_slot;
    logic [7:0]  free_index;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  alloc_class;
    logic [1:0]  alloc_slot;
    logic [7:0]  alloc_index;
    logic [12:0] class_bytes;
    logic [3:0]  page_order;
    logic [19:0] used_bytes;
  } rsp_t;

  function automatic logic [12:0] class_size(input logic [3:0] c);
    return 13'(13'd16 << c);
  endfunction

  // Objects per slab for a given header size, capped at 256
  function automatic logic [8:0] objects_of(input logic [3:0] c, input int hdr);
    int room;
    int n;
    room = (c >= 4'd6) ? 8192 : 4096;
    n = (room - hdr) >> (c + 4);
    if (room <= hdr) n = 0;
    if (n > 256) n = 256;
    return 9'(n);
  endfunction

endpackage

FILE: rtl/sba_ffs.sv
// ----------------------------------------------------------------------------
// Slab bitmap allocator find-first-set
// Registered search for the lowest set bit of a 256-bit map, in two levels.
// ----------------------------------------------------------------------------
module sba_ffs (
  input  logic         clk,
  input  logic [255:0] map,
  output logic         found,
  output logic [7:0]   index
);

  logic [15:0] grp_any;
  logic [15:0][3:0] grp_low;
  logic [15:0] grp_any_q;
  logic [15:0][3:0] grp_low_q;

  always_comb begin
    for (int g = 0; g < 16; g++) begin
      grp_any[g] = |map[g*16 +: 16];
      grp_low[g] = 4'd0;
      for (int b = 15; b >= 0; b--) begin
        if (map[g*16 + b]) grp_low[g] = 4'(b);
      end
    end
  end

  always_ff @(posedge clk) begin
    grp_any_q <= grp_any;
    grp_low_q <= grp_low;
  end

  always_comb begin
    found = |grp_any_q;
    index = 8'd0;
    for (int g = 15; g >= 0; g--) begin
      if (grp_any_q[g]) index = {4'(g), grp_low_q[g]};
    end
  end

endmodule

FILE: rtl/slab_bitmap_allocator_top.sv
// Requests rejected on their fields alone answer from the idle state, a foreign slab or
//   no free slab from the open state, a double free from the search state; frees and
//   grants end in the write state. One request at a time; the result waits in an output
//   register, so a stalled output blocks input only once a second result is ready.
// Reset: synchronous; clears slab valid bits and the used-bytes total. The free-map and
//   free-count memories need no clearing; the block is ready at once.
// ----------------------------------------------------------------------------
// Slab bitmap allocator top level
// Nine slab size classes with free bitmaps kept in on-chip memory.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module slab_bitmap_allocator_top #(
  parameter int SLABS_PER_CLASS = 4,
  parameter int HEADER_BYTES    = 120
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  sba_pkg::req_t in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output sba_pkg::rsp_t out_data
);

  localparam int NSLOT = sba_pkg::NUM_CLASSES * SLABS_PER_CLASS;
  localparam int EW    = $clog2(NSLOT);
  localparam int SW    = (SLABS_PER_CLASS > 1) ? $clog2(SLABS_PER_CLASS) : 1;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_READ  = 3'd1;
  localparam logic [2:0] S_SRCH  = 3'd2;
  localparam logic [2:0] S_WRITE = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;
  localparam logic [2:0] S_OPEN  = 3'd5;

  logic [2:0] state;
  sba_pkg::req_t req;
  sba_pkg::rsp_t rsp;
  logic          rsp_valid;
  logic [NSLOT-1:0] slab_valid;
  logic [19:0] used;

  logic [255:0] map_mem [NSLOT];
  logic [8:0]   left_mem [NSLOT];
  logic [255:0] map_rd;
  logic [8:0]   left_rd;
  logic [EW-1:0] rd_addr;
  logic [EW-1:0] ent;
  logic [SW-1:0] slot;
  logic [3:0]    cls;
  logic [8:0]    objs;
  logic [255:0]  init_map;
  logic          wr_en;
  logic [255:0]  wr_map;
  logic [8:0]    wr_left;
  logic [255:0]  map_q;
  logic [8:0]    left_q;
  logic          ffs_found;
  logic [7:0]    ffs_index;

  // Synchronous memories, one read port each
  always_ff @(posedge clk) begin
    map_rd  <= map_mem[rd_addr];
    left_rd <= left_mem[rd_addr];
    if (wr_en) begin
      map_mem[ent]  <= wr_map;
      left_mem[ent] <= wr_left;
    end
  end

  sba_ffs u_ffs (.clk(clk), .map(map_q), .found(ffs_found), .index(ffs_index));

  // Class of the request and scan for a slot
  logic [3:0]    acls;
  logic          is_bad;
  logic          is_large;
  logic [3:0]    order;
  logic [24:0]   pages_raw;
  logic          hit;
  logic [SW-1:0] hit_slot;
  logic          has_open;
  logic [SW-1:0] open_slot;
  logic [8:0]    req_objs;
  logic [EW-1:0] req_ent;

  always_comb begin
    logic [24:0] sum;
    acls = 4'd0;
    for (int k = 8; k >= 0; k--) begin
      if (in_data.request_size <= 24'(sba_pkg::class_size(4'(k)))) acls = 4'(k);
    end
    is_bad   = (in_data.request_size == 24'd0) || (in_data.request_size > sba_pkg::BIG_LIMIT);
    is_large = in_data.request_size > 24'd4096;
    sum = 25'(in_data.request_size) + 25'(HEADER_BYTES - 64) + 25'd4095;
    pages_raw = sum >> 12;
    order = 4'd0;
    for (int k = 12; k >= 0; k--) begin
      if ((25'd1 << k) >= pages_raw) order = 4'(k);
    end
  end

  // Slot scan uses one room flag per slab, kept beside the free-count memory
  logic [NSLOT-1:0] has_room;
  always_comb begin
    hit = 1'b0;
    hit_slot = '0;
    has_open = 1'b0;
    open_slot = '0;
    for (int s = 0; s < SLABS_PER_CLASS; s++) begin
      if (!slab_valid[int'(cls) * SLABS_PER_CLASS + s]) begin
        has_open = 1'b1;
        open_slot = SW'(s);
      end
    end
    for (int s = SLABS_PER_CLASS - 1; s >= 0; s--) begin
      if (!slab_valid[int'(cls) * SLABS_PER_CLASS + s]) begin
        has_open = 1'b1;
        open_slot = SW'(s);
      end
    end
    for (int s = 0; s < SLABS_PER_CLASS; s++) begin
      if (slab_valid[int'(cls) * SLABS_PER_CLASS + s]
          && has_room[int'(cls) * SLABS_PER_CLASS + s]) begin
        hit = 1'b1;
        hit_slot = SW'(s);
      end
    end
    req_objs = sba_pkg::objects_of(cls, HEADER_BYTES);
    req_ent  = EW'(int'(cls) * SLABS_PER_CLASS);
  end

  always_comb begin
    for (int i = 0; i < 256; i++) init_map[i] = (9'(i) < objs);
  end

  assign in_ready  = (state == S_IDLE) && !rsp_valid;

  logic [EW-1:0] sel_ent;
  assign sel_ent = EW'(int'(cls) * SLABS_PER_CLASS + int'(slot));
  // Issue the read for the hit slot while the scan picks it
  assign rd_addr = (state == S_OPEN && !mode_free)
                   ? EW'(int'(req_ent) + int'(hit_slot)) : sel_ent;
  assign wr_en   = (state == S_WRITE);

  logic [12:0] cbytes;
  assign cbytes = sba_pkg::class_size(cls);
  logic        mode_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      rsp_valid  <= 1'b0;
      slab_valid <= '0;
      used       <= 20'd0;
    end else begin
      // Move a finished response into the output register when it is free
      if (!out_valid || out_ready) begin
        out_valid <= rsp_valid;
        if (rsp_valid) begin
          out_data  <= rsp;
          rsp_valid <= 1'b0;
        end
      end
      case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            req <= in_data;
            mode_free <= in_data.req_type;
            if (in_data.req_type) begin
              cls  <= in_data.free_class;
              slot <= SW'(in_data.free_slot);
              if (in_data.free_class >= 4'd9
                  || 32'(in_data.free_slot) >= 32'(SLABS_PER_CLASS)) begin
                rsp <= '{status: sba_pkg::ST_FOREIGN, used_bytes: used, default: '0};
                rsp_valid <= 1'b1;
              end else begin
                rsp <= '{used_bytes: used, default: '0};
                state <= S_OPEN;
              end
            end else if (is_bad) begin
              rsp <= '{status: sba_pkg::ST_BAD_SIZE, used_bytes: used, default: '0};
              rsp_valid <= 1'b1;
            end else if (is_large) begin
              rsp <= '{status: sba_pkg::ST_LARGE, page_order: order, used_bytes: used,
                       default: '0};
              rsp_valid <= 1'b1;
            end else begin
              rsp   <= '{used_bytes: used, default: '0};
              cls   <= acls;
              state <= S_OPEN;
            end
          end
        end
        S_OPEN: begin
          objs <= req_objs;
          if (mode_free) begin
            if (!slab_valid[sel_ent] || 9'(req.free_index) >= req_objs) begin
              rsp.status <= sba_pkg::ST_FOREIGN;
              rsp_valid <= 1'b1;
              state <= S_IDLE;
            end else begin
              state <= S_READ;
            end
          end else if (hit) begin
            slot  <= hit_slot;
            state <= S_READ;
          end else if (has_open && req_objs != 9'd0) begin
            slot  <= open_slot;
            slab_valid[int'(req_ent) + int'(open_slot)] <= 1'b1;
            state <= S_READ;
            map_q <= '1;
          end else begin
            rsp.status <= sba_pkg::ST_NO_SLABS;
            rsp_valid <= 1'b1;
            state <= S_IDLE;
          end
          // remember whether this slot is freshly opened
          left_q <= (!mode_free && !hit) ? 9'h1FF : 9'd0;
        end
        S_READ: begin
          // read data arrives now; replace with initial contents on open
          if (left_q == 9'h1FF) begin
            map_q  <= init_map;
            left_q <= objs;
          end else begin
            map_q  <= map_rd;
            left_q <= left_rd;
          end
          state <= S_SRCH;
        end
        S_SRCH: begin
          if (mode_free) begin
            if (map_q[req.free_index]) begin
              rsp.status <= sba_pkg::ST_DOUBLE;
              rsp_valid <= 1'b1;
              state <= S_IDLE;
            end else begin
              map_q[req.free_index] <= 1'b1;
              left_q <= left_q + 9'd1;
              wr_map <= map_q | (256'd1 << req.free_index);
              wr_left <= left_q + 9'd1;
              ent <= sel_ent;
              rsp.class_bytes <= cbytes;
              rsp.used_bytes <= used - 20'(cbytes);
              used <= used - 20'(cbytes);
              state <= S_WRITE;
            end
          end else begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          // search result is registered inside the finder
          wr_map  <= map_q & ~(256'd1 << ffs_index);
          wr_left <= left_q - 9'd1;
          ent     <= sel_ent;
          rsp.alloc_class <= cls;
          rsp.alloc_slot  <= 2'(slot);
          rsp.alloc_index <= ffs_index;
          rsp.class_bytes <= cbytes;
          rsp.used_bytes  <= used + 20'(cbytes);
          used  <= used + 20'(cbytes);
          state <= S_WRITE;
        end
        S_WRITE: begin
          rsp_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Room flags for the slot scan, updated with each write-back
  always_ff @(posedge clk) begin
    if (wr_en) has_room[ent] <= (wr_left != 9'd0);
  end

  `ASSERT_IMPL(a_busy_not_ready, clk, rst, state != S_IDLE, !in_ready)
  `ASSERT_NEXT(a_write_then_rsp, clk, rst, state == S_WRITE, rsp_valid)
  `ASSERT_IMPL(a_write_valid, clk, rst, state == S_WRITE, slab_valid[ent])
  `ASSERT_IMPL(a_alloc_found, clk, rst, state == S_DONE, ffs_found)
  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_data))

endmodule
